// File: hw/rtl/occupancy_grid_ray_update_top_macros.svh
// Assertion macros for the occupancy grid ray update block.
// Included by files that carry concurrent checks; clocked on aclk, held off in reset.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define OGRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define OGRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OGRU_ASSERT(lbl, prop, msg)

`define OGRU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ogru_pkg.sv
// Shared constants, types and cell arithmetic for the occupancy grid ray update block.
// No dependencies.
package ogru_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);

    localparam int COORD_W   = 10;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int ERR_W     = DELTA_W + 2;
    localparam int CELL_W    = 8;
    localparam int AMT_W     = 7;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_CELLS = 1 << COORD_W;

    localparam logic [AMT_W-1:0] HIT_RESET  = 7'd3;
    localparam logic [AMT_W-1:0] MISS_RESET = 7'd1;

    localparam logic [CFG_IDX_W-1:0] REG_HIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS = 1'd1;

    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CELL_W-1:0]  cell_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [AMT_W-1:0]          amt_t;

    localparam cell_t CELL_MIN = 8'sh80;
    localparam cell_t CELL_MAX = 8'sh7F;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    function automatic logic on_grid(coord_t x, coord_t y);
        return (x >= 0) && (int'(x) < GRID_WIDTH) && (y >= 0) && (int'(y) < GRID_HEIGHT);
    endfunction

    function automatic addr_t cell_addr(coord_t x, coord_t y);
        return addr_t'(int'(y) * GRID_WIDTH + int'(x));
    endfunction

    function automatic cell_t sat_add(cell_t v, amt_t a);
        logic signed [CELL_W:0] s;
        s = (CELL_W+1)'(v) + $signed({2'b00, a});
        return (s > (CELL_W+1)'(CELL_MAX)) ? CELL_MAX : cell_t'(s);
    endfunction

    function automatic cell_t sat_sub(cell_t v, amt_t a);
        logic signed [CELL_W:0] d;
        d = (CELL_W+1)'(v) - $signed({2'b00, a});
        return (d < (CELL_W+1)'(CELL_MIN)) ? CELL_MIN : cell_t'(d);
    endfunction

endpackage

// File: hw/rtl/occupancy_grid_ray_update_top.sv
// Occupancy grid ray update: log-odds grid in one synchronous RAM, Bresenham walker.
// Depends on ogru_pkg and occupancy_grid_ray_update_top_macros.svh.
//
// After reset the grid RAM is swept to zero, one cell per cycle, over all GRID_DEPTH
// cells (65536 at 256 x 256); s_ready stays low during the sweep while register
// writes are taken as usual. One item is in work at a time. A ray covering N cells
// (N = max(|dx|, |dy|) + 1, up to 1024) is accepted, walked at one cell per cycle,
// and its result word is registered in ST_FINISH once the output register is free
// (a read word walks its single cell). Each on-grid cell of a ray gets a single
// RAM read-modify-write, with the read of one cell overlapping the write of the
// cell before it. The next word is accepted in the cycle after a result is
// registered, even while that result waits on m_ready.
`include "occupancy_grid_ray_update_top_macros.svh"

module occupancy_grid_ray_update_top
    import ogru_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [AMT_W-1:0]           cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic signed [COORD_W-1:0]  s_start_x,
    input  logic signed [COORD_W-1:0]  s_start_y,
    input  logic signed [COORD_W-1:0]  s_end_x,
    input  logic signed [COORD_W-1:0]  s_end_y,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [CELL_W-1:0]   m_cell_value,
    output logic [COUNT_W-1:0]         m_cells_updated,
    output logic                       m_off_grid
);

    state_t state_reg, state_next;

    amt_t               hit_reg, miss_reg;
    addr_t              clr_addr_reg;
    logic               op_reg;
    coord_t             px_reg, py_reg, x1_reg, y1_reg;
    logic [DELTA_W-1:0] dx_reg, dy_reg;
    logic               sx_neg_reg, sy_neg_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic               p1_valid_reg, p1_end_reg;
    addr_t              p1_addr_reg;
    cell_t              rd_data_reg;

    cell_t              value_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               off_reg;

    logic               m_valid_reg;
    cell_t              m_value_reg;
    logic [COUNT_W-1:0] m_cnt_reg;
    logic               m_off_reg;

    cell_t mem [GRID_DEPTH];

    // accept-time setup
    coord_t                   ex, ey;
    logic signed [DELTA_W-1:0] ddx, ddy;
    logic [DELTA_W-1:0]       adx, ady;

    // walker step
    logic                     cur_on, cur_end;
    logic signed [ERR_W:0]    e2, dx_w, dy_w, err_w;
    logic                     c1, c2;
    logic signed [ERR_W-1:0]  err_step;
    coord_t                   px_step, py_step;

    // cell update and ram ports
    cell_t  new_val;
    logic   mem_re, mem_we, out_load;
    addr_t  mem_raddr, mem_waddr;
    cell_t  mem_wdata;

    always_comb begin
        ex  = (s_op == OP_READ) ? s_start_x : s_end_x;
        ey  = (s_op == OP_READ) ? s_start_y : s_end_y;
        ddx = DELTA_W'(ex) - DELTA_W'(s_start_x);
        ddy = DELTA_W'(ey) - DELTA_W'(s_start_y);
        adx = ddx[DELTA_W-1] ? DELTA_W'(-ddx) : DELTA_W'(ddx);
        ady = ddy[DELTA_W-1] ? DELTA_W'(-ddy) : DELTA_W'(ddy);
    end

    always_comb begin
        cur_on  = on_grid(px_reg, py_reg);
        cur_end = (px_reg == x1_reg) && (py_reg == y1_reg);
        e2      = $signed({err_reg, 1'b0});
        dx_w    = $signed({3'b000, dx_reg});
        dy_w    = $signed({3'b000, dy_reg});
        err_w   = (ERR_W+1)'(err_reg);
        c1      = (e2 >= -dy_w);
        c2      = (e2 <= dx_w);
        err_step = ERR_W'(err_w - (c1 ? dy_w : '0) + (c2 ? dx_w : '0));
        px_step = px_reg;
        py_step = py_reg;
        if (c1) begin
            px_step = sx_neg_reg ? px_reg - coord_t'(1) : px_reg + coord_t'(1);
        end
        if (c2) begin
            py_step = sy_neg_reg ? py_reg - coord_t'(1) : py_reg + coord_t'(1);
        end
        new_val = p1_end_reg ? sat_add(rd_data_reg, hit_reg) : sat_sub(rd_data_reg, miss_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == addr_t'(GRID_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cur_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(px_reg, py_reg);
        mem_we    = p1_valid_reg && (op_reg == OP_RAY);
        mem_waddr = p1_addr_reg;
        mem_wdata = new_val;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_WALK: begin
                mem_re = cur_on;
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            hit_reg      <= HIT_RESET;
            miss_reg     <= MISS_RESET;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_HIT:  hit_reg  <= cfg_wdata;
                    REG_MISS: miss_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + addr_t'(1);
            end

            p1_valid_reg <= (state_reg == ST_WALK) && cur_on;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_op;
            px_reg     <= s_start_x;
            py_reg     <= s_start_y;
            x1_reg     <= ex;
            y1_reg     <= ey;
            dx_reg     <= adx;
            dy_reg     <= ady;
            sx_neg_reg <= !(s_start_x < ex);
            sy_neg_reg <= !(s_start_y < ey);
            err_reg    <= ERR_W'($signed({2'b00, adx}) - $signed({2'b00, ady}));
            value_reg  <= '0;
            cnt_reg    <= '0;
            off_reg    <= 1'b0;
        end

        if (state_reg == ST_WALK) begin
            p1_end_reg  <= cur_end;
            p1_addr_reg <= mem_raddr;
            if (!cur_on) begin
                off_reg <= 1'b1;
            end
            if (!cur_end) begin
                px_reg  <= px_step;
                py_reg  <= py_step;
                err_reg <= err_step;
            end
        end

        if (p1_valid_reg) begin
            if (op_reg == OP_READ) begin
                value_reg <= rd_data_reg;
            end else begin
                cnt_reg <= cnt_reg + COUNT_W'(1);
                if (p1_end_reg) begin
                    value_reg <= new_val;
                end
            end
        end

        if (out_load) begin
            m_value_reg <= value_reg;
            m_cnt_reg   <= cnt_reg;
            m_off_reg   <= off_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_value    = m_value_reg;
    assign m_cells_updated = m_cnt_reg;
    assign m_off_grid      = m_off_reg;

    `OGRU_ASSERT(a_rw_distinct, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "read and write hit same cell")
    `OGRU_ASSERT(a_p1_in_walk, p1_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN), "stale pipeline word")
    `OGRU_ASSERT(a_cnt_bound, (state_reg == ST_FINISH) |-> (cnt_reg <= COUNT_W'(MAX_CELLS)), "cell count overrun")
    `OGRU_ASSERT(a_read_no_cnt, (state_reg == ST_FINISH && op_reg == OP_READ) |-> (cnt_reg == '0), "read word wrote cells")
    `OGRU_ASSERT_NEXT(a_load_valid, out_load, m_valid_reg, "result not presented")

endmodule

// File: bench/tb_occupancy_grid_ray_update_top.sv
// Self-checking bench for occupancy_grid_ray_update_top: ray and read words against a grid model.
// Depends on ogru_pkg and the RTL; directed table first, then random phases with idling.
// Register settings change between phases, and one phase stalls the result side for a long stretch.
module tb_occupancy_grid_ray_update_top;
    import ogru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 270000;
    localparam int PHASE_WORDS    = 270;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct packed {
        logic   op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } ray_word_t;

    typedef struct packed {
        cell_t              value;
        logic [COUNT_W-1:0] count;
        logic               off;
    } ray_result_t;

    typedef struct packed {
        ray_word_t   word;
        logic        known;
        ray_result_t result;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AMT_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    coord_t             s_start_x;
    coord_t             s_start_y;
    coord_t             s_end_x;
    coord_t             s_end_y;
    logic               m_valid;
    logic               m_ready;
    cell_t              m_cell_value;
    logic [COUNT_W-1:0] m_cells_updated;
    logic               m_off_grid;

    cell_t       grid_model [GRID_DEPTH];
    amt_t        hit_amt;
    amt_t        miss_amt;
    ray_result_t due_results [$];
    dir_row_t    dir_q [$];
    ray_result_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int errors         = 0;
    int n_rays         = 0;
    int n_reads        = 0;
    int n_off          = 0;

    occupancy_grid_ray_update_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value),
        .m_cells_updated (m_cells_updated),
        .m_off_grid      (m_off_grid)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic logic inside_grid(int x, int y);
        return x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT;
    endfunction

    // Applies a word to the model grid (Bresenham walk, or one-cell read) and returns its result.
    function automatic ray_result_t apply_to_grid(ray_word_t w);
        ray_result_t r;
        int x0, y0, x1, y1, dx, dy, stx, sty, err, e2, px, py, v, a, cnt;
        r = '0;
        cnt = 0;
        x0 = int'(w.start_x);
        y0 = int'(w.start_y);
        x1 = int'(w.end_x);
        y1 = int'(w.end_y);
        if (w.op == OP_READ) begin
            if (inside_grid(x0, y0))
                r.value = grid_model[y0 * GRID_WIDTH + x0];
            else
                r.off = 1'b1;
        end else begin
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            stx = (x0 < x1) ? 1 : -1;
            sty = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            px = x0;
            py = y0;
            while (px != x1 || py != y1) begin
                if (inside_grid(px, py)) begin
                    a = py * GRID_WIDTH + px;
                    v = int'(grid_model[a]) - int'(miss_amt);
                    grid_model[a] = cell_t'((v < -128) ? -128 : v);
                    cnt++;
                end else begin
                    r.off = 1'b1;
                end
                e2 = 2 * err;
                if (e2 >= -dy) begin
                    err -= dy;
                    px += stx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    py += sty;
                end
            end
            if (inside_grid(px, py)) begin
                a = py * GRID_WIDTH + px;
                v = int'(grid_model[a]) + int'(hit_amt);
                grid_model[a] = cell_t'((v > 127) ? 127 : v);
                r.value = grid_model[a];
                cnt++;
            end else begin
                r.off = 1'b1;
            end
            r.count = cnt[COUNT_W-1:0];
        end
        return r;
    endfunction

    function automatic dir_row_t dir_row(logic op, int sx, int sy, int ex, int ey,
                                         int known, int v, int c, int o);
        dir_row_t d;
        d.word.op      = op;
        d.word.start_x = coord_t'(sx);
        d.word.start_y = coord_t'(sy);
        d.word.end_x   = coord_t'(ex);
        d.word.end_y   = coord_t'(ey);
        d.known        = known[0];
        d.result.value = cell_t'(v);
        d.result.count = COUNT_W'(c);
        d.result.off   = o[0];
        return d;
    endfunction

    // Mostly short rays in a small corner so cells get hit repeatedly and saturate.
    function automatic ray_word_t random_word();
        ray_word_t w;
        int pick, sx, sy;
        pick = int'($urandom_range(99));
        w.op = OP_RAY;
        if (pick < 75) begin
            sx = int'($urandom_range(44)) - 4;
            sy = int'($urandom_range(44)) - 4;
            w.start_x = coord_t'(sx);
            w.start_y = coord_t'(sy);
            w.end_x = coord_t'(sx + int'($urandom_range(24)) - 12);
            w.end_y = coord_t'(sy + int'($urandom_range(24)) - 12);
            if (pick >= 65) begin
                w.op = OP_READ;
                w.end_x = coord_t'($urandom);
                w.end_y = coord_t'($urandom);
            end
        end else if (pick < 85) begin
            w.start_x = coord_t'(int'($urandom_range(259)) - 2);
            w.start_y = coord_t'(int'($urandom_range(259)) - 2);
            w.end_x = coord_t'(int'($urandom_range(259)) - 2);
            w.end_y = coord_t'(int'($urandom_range(259)) - 2);
        end else begin
            w.start_x = coord_t'($urandom);
            w.start_y = coord_t'($urandom);
            w.end_x = coord_t'($urandom);
            w.end_y = coord_t'($urandom);
            if (pick >= 93)
                w.op = OP_READ;
        end
        return w;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(input ray_word_t w, input ray_result_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_op      = w.op;
        s_start_x = w.start_x;
        s_start_y = w.start_y;
        s_end_x   = w.end_x;
        s_end_y   = w.end_y;
        s_valid   = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        due_results.push_back(res);
        if (w.op == OP_READ)
            n_reads++;
        else
            n_rays++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = amt_t'(value);
        if (idx == REG_HIT)
            hit_amt = amt_t'(value);
        else
            miss_amt = amt_t'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: value %0d count %0d off %0d",
                         $time, m_cell_value, m_cells_updated, m_off_grid);
            end else begin
                want = due_results.pop_front();
                if (m_cell_value !== want.value) begin
                    errors++;
                    $display("%0t: cell_value expected %0d got %0d",
                             $time, want.value, m_cell_value);
                end
                if (m_cells_updated !== want.count) begin
                    errors++;
                    $display("%0t: cells_updated expected %0d got %0d",
                             $time, want.count, m_cells_updated);
                end
                if (m_off_grid !== want.off) begin
                    errors++;
                    $display("%0t: off_grid expected %0d got %0d",
                             $time, want.off, m_off_grid);
                end
                if (m_off_grid)
                    n_off++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("tb_occupancy_grid_ray_update_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        ray_word_t   w;
        ray_result_t p;
        int          ph, i;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_op      = OP_RAY;
        s_start_x = '0;
        s_start_y = '0;
        s_end_x   = '0;
        s_end_y   = '0;
        foreach (grid_model[k])
            grid_model[k] = '0;
        hit_amt  = HIT_RESET;
        miss_amt = MISS_RESET;

        //                     op       sx    sy    ex    ey  known val cnt off
        dir_q.push_back(dir_row(OP_READ,    0,    0,    0,    0, 1,  0,   0, 0));
        dir_q.push_back(dir_row(OP_READ, -512, -512,  511,  511, 1,  0,   0, 1));
        dir_q.push_back(dir_row(OP_READ,  511,  511,    0,    0, 1,  0,   0, 1));
        dir_q.push_back(dir_row(OP_READ,  255,  255,    0,    0, 1,  0,   0, 0));
        dir_q.push_back(dir_row(OP_READ,  256,    0,    0,    0, 1,  0,   0, 1));
        dir_q.push_back(dir_row(OP_READ,    0,  256,    0,    0, 1,  0,   0, 1));
        dir_q.push_back(dir_row(OP_RAY,    10,   10,   10,   10, 1,  3,   1, 0));
        dir_q.push_back(dir_row(OP_READ,   10,   10,    0,    0, 1,  3,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,     0,    0,    5,    0, 1,  3,   6, 0));
        dir_q.push_back(dir_row(OP_READ,    2,    0,    0,    0, 1, -1,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,  -512, -512, -500, -510, 1,  0,   0, 1));
        dir_q.push_back(dir_row(OP_RAY,    -3,    0,    2,    0, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,   511, -512, -512,  511, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,     0,    0,  255,  255, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,   255,    0,    0,  255, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,   300,   10,  250,   10, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,    10,   10,   10,  300, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,     5,    5,    7,   20, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,    20,   20,    3,   17, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_READ,    3,    0,  511, -512, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_RAY,   511,  511, -512, -512, 0,  0,   0, 0));
        dir_q.push_back(dir_row(OP_READ,    0,    0,    0,    0, 0,  0,   0, 0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_q[j]) begin
            p = apply_to_grid(dir_q[j].word);
            send_word(dir_q[j].word, dir_q[j].known ? dir_q[j].result : p);
        end
        drain_results();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(REG_HIT, 127);
                    write_reg(REG_MISS, 127);
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                    write_reg(REG_HIT, 0);
                    write_reg(REG_MISS, 0);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                    write_reg(REG_HIT, int'($urandom_range(127)));
                    write_reg(REG_MISS, int'($urandom_range(127)));
                    @(posedge aclk);
                    hold_left = HOLD_CYCLES;
                    @(negedge aclk);
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                    write_reg(REG_HIT, int'($urandom_range(127)));
                    write_reg(REG_MISS, int'($urandom_range(127)));
                end
            endcase
            for (i = 0; i < PHASE_WORDS; i++) begin
                w = random_word();
                send_word(w, apply_to_grid(w));
            end
            drain_results();
        end

        repeat (64) @(posedge aclk);
        $display("Run covered %0d ray words and %0d read words over five register settings",
                 n_rays, n_reads);
        $display("and four handshake mixes; %0d results flagged off grid, %0d mismatches",
                 n_off, errors);
        if (errors == 0)
            $display("tb_occupancy_grid_ray_update_top OK");
        else
            $display("tb_occupancy_grid_ray_update_top NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ogru_pkg.sv
hw/rtl/occupancy_grid_ray_update_top.sv
bench/tb_occupancy_grid_ray_update_top.sv
